// ===== rtl/cvr_pkg.sv =====
// Package for the multi-channel 1D convolution unit: command codes,
// configuration register indexes and the controller-to-datapath command struct.
// No dependencies.
package cvr_pkg;

  // Input commands.
  localparam logic [2:0] CMD_LOAD_WEIGHT = 3'd0;
  localparam logic [2:0] CMD_LOAD_BIAS   = 3'd1;
  localparam logic [2:0] CMD_SAMPLE      = 3'd2;
  localparam logic [2:0] CMD_PAD         = 3'd3;
  localparam logic [2:0] CMD_START_LINE  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_IN_CHANNELS  = 2'd0;
  localparam logic [1:0] REG_OUT_CHANNELS = 2'd1;
  localparam logic [1:0] REG_RESULT_SHIFT = 2'd2;

  // Field widths of the command struct, sized for the widest parameter range.
  localparam int ROW_BITS = 4;
  localparam int CH_BITS  = 6;
  localparam int FLT_BITS = 6;

  // Accumulator width; wide enough that the sum never wraps before clamping.
  localparam int ACC_BITS = 48;

  typedef struct packed {
    logic                wr_weight;  // store a weight from the input fields
    logic                wr_bias;    // store a bias from the input fields
    logic                wr_sample;  // store a sample into the window
    logic [ROW_BITS-1:0] wr_row;     // window row that takes the sample
    logic                push;       // clear the row that becomes the newest
    logic [ROW_BITS-1:0] push_row;
    logic                clear_all;  // start of line: clear the whole window
    logic                rd;         // issue one multiply-accumulate read
    logic                rd_first;   // first product of a filter, load the bias
    logic                rd_last;    // last product of a filter
    logic [ROW_BITS-1:0] rd_row;     // physical window row
    logic [ROW_BITS-1:0] rd_tap;     // kernel tap
    logic [CH_BITS-1:0]  rd_ch;
    logic [FLT_BITS-1:0] filt;       // filter being computed
    logic                filt_last;  // filter is the last of the position
    logic [4:0]          shift;      // result shift
  } cmd_t;

endpackage

// ===== rtl/cvr_datapath.sv =====
// Datapath of the convolution unit: window, weight and bias memories, the
// multiply-accumulate pipeline, result formatting and the output register.
// Depends on cvr_pkg.
module cvr_datapath import cvr_pkg::*; #(
  parameter int TAPS     = 5,
  parameter int CIN_MAX  = 32,
  parameter int COUT_MAX = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic signed [31:0] data_value_i,
  input  logic [3:0]         tap_index_i,
  input  logic [4:0]         channel_index_i,
  input  logic [4:0]         filter_index_i,
  output logic               loaded_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        result_value_o,
  output logic [4:0]         result_filter_o,
  output logic               last_of_position_o
);

  localparam int RW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW = (CIN_MAX > 1) ? $clog2(CIN_MAX) : 1;
  localparam int FW = (COUT_MAX > 1) ? $clog2(COUT_MAX) : 1;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = ACC_BITS'(64'h7F_FFFF_FFFF);

  logic signed [15:0] win_mem [TAPS][CIN_MAX];
  logic signed [15:0] wt_mem  [TAPS][CIN_MAX][COUT_MAX];
  logic signed [31:0] bias_mem [COUT_MAX];
  logic [CIN_MAX-1:0] vld_q [TAPS];
  logic [CIN_MAX-1:0] vld_d [TAPS];

  logic signed [15:0] data_sat;
  logic               s1_vld_q, s1_first_q, s1_last_q, win_ok_q;
  logic signed [15:0] win_rd_q, wt_rd_q;
  logic signed [31:0] bias1_q, bias2_q;
  logic               s2_vld_q, s2_first_q, s2_last_q;
  logic signed [31:0] prod_q;
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic               fin_q;
  logic               load;
  logic signed [ACC_BITS-1:0] acc_clamped;
  logic [39:0]        shifted;
  logic [14:0]        res;
  logic               out_vld_q, out_last_q;
  logic [14:0]        out_val_q;
  logic [4:0]         out_flt_q;

  always_comb begin
    if (data_value_i > 32'sd32767) begin
      data_sat = 16'sh7FFF;
    end else if (data_value_i < -32'sd32768) begin
      data_sat = -16'sh8000;
    end else begin
      data_sat = data_value_i[15:0];
    end
  end

  // Valid bits: an entry that is not valid reads as zero.
  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      vld_d[r] = vld_q[r];
      if (cmd_i.clear_all || (cmd_i.push && cmd_i.push_row[RW-1:0] == RW'(r))) begin
        vld_d[r] = '0;
      end
      for (int c = 0; c < CIN_MAX; c++) begin
        if (cmd_i.wr_sample && cmd_i.wr_row[RW-1:0] == RW'(r) &&
            CW'(channel_index_i) == CW'(c)) begin
          vld_d[r][c] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < TAPS; r++) vld_q[r] <= '0;
    end else begin
      for (int r = 0; r < TAPS; r++) vld_q[r] <= vld_d[r];
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sample) begin
      win_mem[cmd_i.wr_row[RW-1:0]][CW'(channel_index_i)] <= data_sat;
    end
    if (cmd_i.wr_weight) begin
      wt_mem[RW'(tap_index_i)][CW'(channel_index_i)][FW'(filter_index_i)] <= data_sat;
    end
    if (cmd_i.wr_bias) begin
      bias_mem[FW'(filter_index_i)] <= data_value_i;
    end
    win_rd_q <= win_mem[cmd_i.rd_row[RW-1:0]][cmd_i.rd_ch[CW-1:0]];
    win_ok_q <= vld_q[cmd_i.rd_row[RW-1:0]][cmd_i.rd_ch[CW-1:0]];
    wt_rd_q  <= wt_mem[cmd_i.rd_tap[RW-1:0]][cmd_i.rd_ch[CW-1:0]][cmd_i.filt[FW-1:0]];
    bias1_q  <= bias_mem[cmd_i.filt[FW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= win_ok_q ? (32'(win_rd_q) * 32'(wt_rd_q)) : 32'sd0;
    bias2_q <= bias1_q;
    acc_q   <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (s2_vld_q) begin
      acc_d = (s2_first_q ? ACC_BITS'(bias2_q) : acc_q) + ACC_BITS'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd;
      s1_first_q <= cmd_i.rd_first;
      s1_last_q  <= cmd_i.rd_last;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      if (s2_vld_q && s2_last_q) begin
        fin_q <= 1'b1;
      end else if (load) begin
        fin_q <= 1'b0;
      end
    end
  end

  // ReLU, clamp to 40 bits, shift and saturate.
  always_comb begin
    acc_clamped = (acc_q > ACC_MAX) ? ACC_MAX : acc_q;
    shifted     = acc_clamped[39:0] >> cmd_i.shift;
    if (acc_q <= 0) begin
      res = '0;
    end else if (shifted > 40'd32767) begin
      res = 15'h7FFF;
    end else begin
      res = shifted[14:0];
    end
  end

  assign load     = fin_q && (!out_vld_q || out_ready_i);
  assign loaded_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_val_q  <= res;
      out_flt_q  <= cmd_i.filt[4:0];
      out_last_q <= cmd_i.filt_last;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign result_value_o     = out_val_q;
  assign result_filter_o    = out_flt_q;
  assign last_of_position_o = out_last_q;

endmodule

// ===== rtl/cvr_controller.sv =====
// Controller of the convolution unit: configuration registers, input command
// decoding, position and fill counting, and the multiply-accumulate sequencer.
// Depends on cvr_pkg.
module cvr_controller import cvr_pkg::*; #(
  parameter int TAPS     = 5,
  parameter int CIN_MAX  = 32,
  parameter int COUT_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [3:0] tap_index_i,
  input  logic [4:0] channel_index_i,
  input  logic [4:0] filter_index_i,
  input  logic       loaded_i,
  output cmd_t       cmd_o
);

  localparam int RW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW  = (CIN_MAX > 1) ? $clog2(CIN_MAX) : 1;
  localparam int FW  = (COUT_MAX > 1) ? $clog2(COUT_MAX) : 1;
  localparam int CNW = $clog2(CIN_MAX + 1);
  localparam int FNW = $clog2(COUT_MAX + 1);
  localparam int EMIT_FILL = TAPS - (TAPS - 1) / 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [5:0]     cin_cfg_q, cout_cfg_q;
  logic [4:0]     shift_q;
  logic [CNW-1:0] cin;
  logic [FNW-1:0] cout;
  logic [CNW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [3:0]     fill_q, fill_d;
  logic [RW-1:0]  oldest_q, oldest_d, newest;
  logic [RW-1:0]  row_q, row_d, tap_q, tap_d;
  logic [CW-1:0]  ch_q, ch_d;
  logic [FW-1:0]  f_q, f_d;
  logic           accept, push, emit, tap_end, ch_end, f_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cin_cfg_q  <= 6'd24;
      cout_cfg_q <= 6'd8;
      shift_q    <= 5'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IN_CHANNELS:  cin_cfg_q  <= cfg_data_i;
        REG_OUT_CHANNELS: cout_cfg_q <= cfg_data_i;
        REG_RESULT_SHIFT: shift_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cin  = (cin_cfg_q == 6'd0) ? CNW'(1) :
                ((32'(cin_cfg_q) > CIN_MAX) ? CNW'(CIN_MAX) : CNW'(cin_cfg_q));
  assign cout = (cout_cfg_q == 6'd0) ? FNW'(1) :
                ((32'(cout_cfg_q) > COUT_MAX) ? FNW'(COUT_MAX) : FNW'(cout_cfg_q));

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign newest     = (oldest_q == '0) ? RW'(TAPS - 1) : oldest_q - RW'(1);
  assign cnt_inc    = cnt_q + CNW'(1);
  assign push       = accept && (cmd_i == CMD_SAMPLE || cmd_i == CMD_PAD) && cnt_q == '0;
  assign tap_end    = (tap_q == RW'(TAPS - 1));
  assign ch_end     = (CNW'(ch_q) == cin - CNW'(1));
  assign f_end      = (FNW'(f_q) == cout - FNW'(1));

  always_comb begin
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    oldest_d = oldest_q;
    emit     = 1'b0;
    if (push) begin
      oldest_d = (oldest_q == RW'(TAPS - 1)) ? '0 : oldest_q + RW'(1);
      if (fill_q != 4'd15) fill_d = fill_q + 4'd1;
    end
    if (accept) begin
      case (cmd_i)
        CMD_SAMPLE: begin
          if (cnt_inc >= cin) begin
            cnt_d = '0;
            emit  = (32'(fill_d) >= EMIT_FILL);
          end else begin
            cnt_d = cnt_inc;
          end
        end
        CMD_PAD: begin
          cnt_d = '0;
          emit  = (32'(fill_d) >= EMIT_FILL);
        end
        CMD_START_LINE: begin
          cnt_d  = '0;
          fill_d = '0;
        end
        default: ;
      endcase
    end
  end

  // Sequencer: one product per cycle over taps and channels of one filter.
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    tap_d   = tap_q;
    ch_d    = ch_q;
    f_d     = f_q;
    unique case (state_q)
      S_IDLE: begin
        if (emit) begin
          state_d = S_RUN;
          row_d   = oldest_d;
          tap_d   = '0;
          ch_d    = '0;
          f_d     = '0;
        end
      end
      S_RUN: begin
        if (ch_end) begin
          ch_d = '0;
          if (tap_end) begin
            state_d = S_WAIT;
          end else begin
            tap_d = tap_q + RW'(1);
            row_d = (row_q == RW'(TAPS - 1)) ? '0 : row_q + RW'(1);
          end
        end else begin
          ch_d = ch_q + CW'(1);
        end
      end
      S_WAIT: begin
        if (loaded_i) begin
          if (f_end) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_RUN;
            f_d     = f_q + FW'(1);
            row_d   = oldest_q;
            tap_d   = '0;
            ch_d    = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      fill_q   <= '0;
      oldest_q <= '0;
      row_q    <= '0;
      tap_q    <= '0;
      ch_q     <= '0;
      f_q      <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      row_q    <= row_d;
      tap_q    <= tap_d;
      ch_q     <= ch_d;
      f_q      <= f_d;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_weight = accept && cmd_i == CMD_LOAD_WEIGHT && 32'(tap_index_i) < TAPS &&
                      32'(channel_index_i) < CIN_MAX && 32'(filter_index_i) < COUT_MAX;
    cmd_o.wr_bias   = accept && cmd_i == CMD_LOAD_BIAS && 32'(filter_index_i) < COUT_MAX;
    cmd_o.wr_sample = accept && cmd_i == CMD_SAMPLE && CNW'(channel_index_i) < cin &&
                      32'(channel_index_i) < CIN_MAX;
    cmd_o.wr_row    = ROW_BITS'(push ? oldest_q : newest);
    cmd_o.push      = push;
    cmd_o.push_row  = ROW_BITS'(oldest_q);
    cmd_o.clear_all = accept && cmd_i == CMD_START_LINE;
    cmd_o.rd        = (state_q == S_RUN);
    cmd_o.rd_first  = (state_q == S_RUN) && tap_q == '0 && ch_q == '0;
    cmd_o.rd_last   = (state_q == S_RUN) && tap_end && ch_end;
    cmd_o.rd_row    = ROW_BITS'(row_q);
    cmd_o.rd_tap    = ROW_BITS'(tap_q);
    cmd_o.rd_ch     = CH_BITS'(ch_q);
    cmd_o.filt      = FLT_BITS'(f_q);
    cmd_o.filt_last = f_end;
    cmd_o.shift     = shift_q;
  end

endmodule

// ===== rtl/conv1d_multichannel_relu_unit.sv =====
// Top level of the multi-channel 1D convolution unit with bias and ReLU.
// Depends on cvr_pkg, cvr_controller and cvr_datapath.
//
// Load weights (Q4.12, saturated to 16 bits) and biases (Q8.24) first, then
// stream samples one channel at a time. When the last channel of a position
// arrives, or a pad request arrives, the unit emits one result per filter for
// the centered position, once it lies inside the line, in filter order, with
// last_of_position set on the final one. A start-line request clears the
// window. Requests that emit nothing do not hold off the next request. An
// emitting request computes the filters one after another on a single
// multiply-accumulate unit: the TAPS * in_channels products of each filter
// pass through the registered memory reads, the multiplier register and the
// accumulator, and the result is then handed to the output register. One
// product is computed at a time, as there is one shared multiplier and the
// weight memory gives one read per cycle. New requests are held off while
// a position is being computed, and a filter result waits for the output
// register to be free before the next filter starts; the output register lets
// the final result wait for its consumer without blocking new requests.
// Configuration writes take effect at once and are meant for idle periods
// only.
module conv1d_multichannel_relu_unit import cvr_pkg::*; #(
  parameter int TAPS     = 5,
  parameter int CIN_MAX  = 32,
  parameter int COUT_MAX = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] data_value_i,
  input  logic [3:0]         tap_index_i,
  input  logic [4:0]         channel_index_i,
  input  logic [4:0]         filter_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        result_value_o,
  output logic [4:0]         result_filter_o,
  output logic               last_of_position_o
);

  cmd_t cmd;
  logic loaded;

  // The controller decodes requests and sequences the products of each filter.
  cvr_controller #(
    .TAPS     (TAPS),
    .CIN_MAX  (CIN_MAX),
    .COUT_MAX (COUT_MAX)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .tap_index_i     (tap_index_i),
    .channel_index_i (channel_index_i),
    .filter_index_i  (filter_index_i),
    .loaded_i        (loaded),
    .cmd_o           (cmd)
  );

  // The datapath holds the memories, the accumulator and the output register.
  cvr_datapath #(
    .TAPS     (TAPS),
    .CIN_MAX  (CIN_MAX),
    .COUT_MAX (COUT_MAX)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .data_value_i       (data_value_i),
    .tap_index_i        (tap_index_i),
    .channel_index_i    (channel_index_i),
    .filter_index_i     (filter_index_i),
    .loaded_o           (loaded),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_value_o     (result_value_o),
    .result_filter_o    (result_filter_o),
    .last_of_position_o (last_of_position_o)
  );

endmodule

// ===== tb/conv1d_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the multi-channel 1D convolution unit: tracks configuration
// writes and requests, predicts every result and compares it on the output.
// Depends on cvr_pkg for command codes and register indexes.
module conv1d_result_checker import cvr_pkg::*; #(
  parameter int TAPS     = 5,
  parameter int CIN_MAX  = 32,
  parameter int COUT_MAX = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] data_value_i,
  input  logic [3:0]         tap_index_i,
  input  logic [4:0]         channel_index_i,
  input  logic [4:0]         filter_index_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [14:0]        result_value_i,
  input  logic [4:0]         result_filter_i,
  input  logic               last_of_position_i,
  output int                 pending_o,
  output int                 failures_o
);

  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;

  typedef struct packed {
    logic [14:0] value;
    logic [4:0]  filt;
    logic        last;
  } filter_result_t;

  filter_result_t expected_results[$];
  shortint        window_mem[TAPS*CIN_MAX];
  shortint        weight_mem[TAPS*CIN_MAX*COUT_MAX];
  int             bias_mem[COUT_MAX];
  int unsigned    chan_seen;
  int unsigned    fill_level;
  logic [5:0]     in_ch_reg;
  logic [5:0]     out_ch_reg;
  logic [4:0]     shift_reg;
  int             failures;

  function automatic shortint sat16(logic signed [31:0] v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return shortint'(v);
  endfunction

  function automatic int unsigned clamp_count(logic [5:0] v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    failures++;
  endtask

  // The window shifts by one position; the newest row starts out zero.
  task automatic push_position();
    for (int i = 0; i < (TAPS - 1) * CIN_MAX; i++) window_mem[i] = window_mem[i + CIN_MAX];
    for (int i = (TAPS - 1) * CIN_MAX; i < TAPS * CIN_MAX; i++) window_mem[i] = 0;
    if (fill_level < 15) fill_level++;
  endtask

  task automatic convolve_position();
    int unsigned    cin;
    int unsigned    cout;
    longint         acc;
    longint         r;
    filter_result_t res;
    cin  = clamp_count(in_ch_reg, CIN_MAX);
    cout = clamp_count(out_ch_reg, COUT_MAX);
    // Nothing comes out until the centered position lies inside the line.
    if (fill_level < TAPS - (TAPS - 1) / 2) return;
    for (int f = 0; f < cout; f++) begin
      acc = 0;
      for (int t = 0; t < TAPS; t++)
        for (int c = 0; c < cin; c++)
          acc += longint'(window_mem[t*CIN_MAX + c]) *
                 longint'(weight_mem[(t*CIN_MAX + c)*COUT_MAX + f]);
      acc += longint'(bias_mem[f]);
      if (acc > ACC_HI) acc = ACC_HI;
      if (acc < ACC_LO) acc = ACC_LO;
      if (acc <= 0) r = 0;
      else begin
        r = acc >>> shift_reg;
        if (r > 32767) r = 32767;
      end
      res.value = r[14:0];
      res.filt  = f[4:0];
      res.last  = (f == cout - 1);
      expected_results.push_back(res);
    end
  endtask

  task automatic apply_request();
    int unsigned cin;
    cin = clamp_count(in_ch_reg, CIN_MAX);
    case (cmd_i)
      CMD_LOAD_WEIGHT: begin
        if (tap_index_i < TAPS && channel_index_i < CIN_MAX && filter_index_i < COUT_MAX)
          weight_mem[(tap_index_i*CIN_MAX + channel_index_i)*COUT_MAX + filter_index_i] =
            sat16(data_value_i);
      end
      CMD_LOAD_BIAS: begin
        if (filter_index_i < COUT_MAX) bias_mem[filter_index_i] = data_value_i;
      end
      CMD_SAMPLE: begin
        if (chan_seen == 0) push_position();
        // A channel beyond the configured count is dropped but still counts.
        if (channel_index_i < cin)
          window_mem[(TAPS - 1)*CIN_MAX + channel_index_i] = sat16(data_value_i);
        chan_seen++;
        if (chan_seen >= cin) begin
          chan_seen = 0;
          convolve_position();
        end
      end
      CMD_PAD: begin
        if (chan_seen == 0) push_position();
        chan_seen = 0;
        convolve_position();
      end
      CMD_START_LINE: begin
        foreach (window_mem[i]) window_mem[i] = 0;
        chan_seen  = 0;
        fill_level = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      foreach (window_mem[i]) window_mem[i] = 0;
      foreach (weight_mem[i]) weight_mem[i] = 0;
      foreach (bias_mem[i]) bias_mem[i] = 0;
      chan_seen  = 0;
      fill_level = 0;
      in_ch_reg  = 6'd24;
      out_ch_reg = 6'd8;
      shift_reg  = 5'd12;
      failures   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, filter", result_filter_i, -1);
        end else begin
          filter_result_t want;
          want = expected_results.pop_front();
          if (result_value_i !== want.value)
            report_mismatch("result_value", result_value_i, want.value);
          if (result_filter_i !== want.filt)
            report_mismatch("result_filter", result_filter_i, want.filt);
          if (last_of_position_i !== want.last)
            report_mismatch("last_of_position", last_of_position_i, want.last);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IN_CHANNELS:  in_ch_reg  = cfg_data_i;
          REG_OUT_CHANNELS: out_ch_reg = cfg_data_i;
          REG_RESULT_SHIFT: shift_reg  = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) apply_request();
    end
    pending_o  = expected_results.size();
    failures_o = failures;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the multi-channel 1D convolution unit: clock, reset,
// request stimulus and verdict. Depends on cvr_pkg, the unit and the checker.
module testbench;
  import cvr_pkg::*;

  localparam int TAPS      = 5;
  localparam int CIN_MAX   = 32;
  localparam int COUT_MAX  = 32;
  localparam int LIMIT     = 800000;
  localparam int DRAIN     = 40;
  // Part of the weight and bias tables that is loaded up front; every
  // configuration used below stays within it.
  localparam int LOAD_CIN  = 4;
  localparam int LOAD_COUT = 4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [5:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         cmd = '0;
  logic signed [31:0] data_value = '0;
  logic [3:0]         tap_index = '0;
  logic [4:0]         channel_index = '0;
  logic [4:0]         filter_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [14:0]        result_value;
  logic [4:0]         result_filter;
  logic               last_of_position;
  int                 pending;
  int                 failures;

  // Idling switches; the final phase of the run turns both off.
  bit          sender_idles = 1'b1;
  bit          sink_idles = 1'b1;
  int unsigned sink_stall = 0;
  int unsigned requests_sent = 0;
  int unsigned cycles = 0;

  conv1d_multichannel_relu_unit #(
    .TAPS(TAPS), .CIN_MAX(CIN_MAX), .COUT_MAX(COUT_MAX)
  ) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .data_value_i(data_value), .tap_index_i(tap_index),
    .channel_index_i(channel_index), .filter_index_i(filter_index),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_value_o(result_value), .result_filter_o(result_filter),
    .last_of_position_o(last_of_position)
  );

  conv1d_result_checker #(
    .TAPS(TAPS), .CIN_MAX(CIN_MAX), .COUT_MAX(COUT_MAX)
  ) checker_inst (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .cmd_i(cmd), .data_value_i(data_value), .tap_index_i(tap_index),
    .channel_index_i(channel_index), .filter_index_i(filter_index),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .result_value_i(result_value), .result_filter_i(result_filter),
    .last_of_position_i(last_of_position),
    .pending_o(pending), .failures_o(failures)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result consumer stalls in random bursts while sink_idles is set.
  always @(posedge clk) begin
    if (!sink_idles) begin
      out_ready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Sample values: mostly moderate Q4.12, with saturating and full-width ones mixed in.
  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sd32767;
      2: return -32'sd32768;
      default: return int'($urandom_range(0, 16383)) - 8192;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_weight();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return 32'sd32767;
      2: return -32'sd32768;
      default: return int'($urandom_range(0, 2047)) - 1024;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_bias();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return int'($urandom_range(0, 1 << 26)) - (1 << 25);
    endcase
  endfunction

  // Present one request and hold it until the unit accepts it. A random gap
  // may come first, so the sender idles at every point of the unit's work.
  task automatic send(logic [2:0] c, logic signed [31:0] d, logic [3:0] t,
                      logic [4:0] ch, logic [4:0] f);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    data_value    <= d;
    tap_index     <= t;
    channel_index <= ch;
    filter_index  <= f;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Stop sending until every predicted result has been consumed, then give
  // the unit time to finish a request that produced nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [5:0] cin, logic [5:0] cout, logic [5:0] shift);
    wait_idle();
    write_reg(REG_IN_CHANNELS, cin);
    write_reg(REG_OUT_CHANNELS, cout);
    write_reg(REG_RESULT_SHIFT, shift);
  endtask

  // One line of samples: mostly complete positions in channel order, with
  // pads, broken positions, table reloads and stray commands mixed in.
  task automatic stream_line(int unsigned cin, int unsigned stop_at);
    int unsigned kind;
    int unsigned n;
    send(CMD_START_LINE, $urandom, 4'($urandom), 5'($urandom), 5'($urandom));
    while (requests_sent < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        for (int c = 0; c < cin; c++)
          send(CMD_SAMPLE, rand_sample(), 4'($urandom), 5'(c), 5'($urandom));
      end else if (kind < 16) begin
        send(CMD_PAD, $urandom, 4'($urandom), 5'($urandom), 5'($urandom));
      end else if (kind == 16) begin
        // A partial position, possibly with out-of-range channels, closed by a pad.
        n = $urandom_range(1, cin);
        for (int i = 0; i < n; i++)
          send(CMD_SAMPLE, rand_sample(), 4'($urandom), 5'($urandom_range(0, 31)),
               5'($urandom));
        send(CMD_PAD, $urandom, 4'($urandom), 5'($urandom), 5'($urandom));
      end else if (kind == 17) begin
        send(CMD_LOAD_WEIGHT, rand_weight(), 4'($urandom_range(0, 15)), 5'($urandom),
             5'($urandom));
      end else if (kind == 18) begin
        send(CMD_LOAD_BIAS, rand_bias(), 4'($urandom), 5'($urandom), 5'($urandom));
      end else begin
        send(3'($urandom_range(CMD_START_LINE + 1, 7)), $urandom, 4'($urandom),
             5'($urandom), 5'($urandom));
      end
    end
    // Trailing pads flush the last centered positions of the line.
    send(CMD_PAD, $urandom, 4'($urandom), 5'($urandom), 5'($urandom));
    send(CMD_PAD, $urandom, 4'($urandom), 5'($urandom), 5'($urandom));
  endtask

  task automatic run_phase(logic [5:0] cin_raw, logic [5:0] cout_raw, logic [5:0] shift,
                           int unsigned budget);
    int unsigned cin;
    int unsigned target;
    cin    = (cin_raw == 0) ? 1 : (cin_raw > CIN_MAX) ? CIN_MAX : int'(cin_raw);
    target = requests_sent + budget;
    configure(cin_raw, cout_raw, shift);
    while (requests_sent < target)
      stream_line(cin, requests_sent + $urandom_range(10, 40));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the used part of the weight and bias tables so that no read ever
    // finds an entry that was never written.
    for (int t = 0; t < TAPS; t++)
      for (int c = 0; c < LOAD_CIN; c++)
        for (int f = 0; f < LOAD_COUT; f++)
          send(CMD_LOAD_WEIGHT, rand_weight(), 4'(t), 5'(c), 5'(f));
    for (int f = 0; f < LOAD_COUT; f++)
      send(CMD_LOAD_BIAS, rand_bias(), 4'($urandom), 5'($urandom), 5'(f));

    // Directed part: saturating samples, out-of-range channels, a pad in the
    // middle of a position, ignored loads and unused command codes.
    configure(6'd2, 6'd3, 6'd12);
    send(CMD_START_LINE, 32'sd0, 4'd0, 5'd0, 5'd0);
    send(CMD_SAMPLE, 32'sh7fffffff, 4'd15, 5'd0, 5'd31);
    send(CMD_SAMPLE, 32'sh80000000, 4'd0, 5'd1, 5'd0);
    send(CMD_SAMPLE, 32'sd32767, 4'd0, 5'd0, 5'd0);
    send(CMD_SAMPLE, -32'sd32768, 4'd0, 5'd31, 5'd0);
    send(CMD_SAMPLE, 32'sd4096, 4'd0, 5'd1, 5'd0);
    send(CMD_PAD, 32'sd0, 4'd0, 5'd0, 5'd0);
    send(CMD_SAMPLE, -32'sd4096, 4'd0, 5'd0, 5'd0);
    send(CMD_PAD, 32'sd0, 4'd0, 5'd0, 5'd0);
    send(CMD_LOAD_WEIGHT, 32'sd100, 4'd15, 5'd0, 5'd0);
    send(CMD_LOAD_WEIGHT, 32'sh7fffffff, 4'd4, 5'd31, 5'd2);
    send(CMD_LOAD_WEIGHT, 32'sh80000000, 4'd0, 5'd1, 5'd1);
    send(CMD_LOAD_BIAS, 32'sh7fffffff, 4'd0, 5'd0, 5'd0);
    send(CMD_LOAD_BIAS, 32'sh80000000, 4'd0, 5'd0, 5'd1);
    send(3'd5, 32'sd0, 4'd0, 5'd0, 5'd0);
    send(3'd7, 32'shffffffff, 4'hf, 5'h1f, 5'h1f);
    send(CMD_SAMPLE, 32'sd8192, 4'd0, 5'd0, 5'd0);
    send(CMD_SAMPLE, 32'sd8192, 4'd0, 5'd1, 5'd0);
    send(CMD_PAD, 32'sd0, 4'd0, 5'd0, 5'd0);
    send(CMD_PAD, 32'sd0, 4'd0, 5'd0, 5'd0);
    send(CMD_START_LINE, 32'sd0, 4'd0, 5'd0, 5'd0);

    // Random phases over several settings, the zero counts among them.
    run_phase(6'd3, 6'd4, 6'd12, 50);
    run_phase(6'd1, 6'd1, 6'd0, 30);
    run_phase(6'd0, 6'd2, 6'd31, 20);
    run_phase(6'd4, 6'd4, 6'd14, 35);
    run_phase(6'd2, 6'd0, 6'd16, 30);
    run_phase(6'd4, 6'd1, 6'd20, 30);
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    run_phase(6'd4, 6'd3, 6'd13, 30);

    wait_idle();
    if (failures == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cvr_pkg.sv
rtl/cvr_datapath.sv
rtl/cvr_controller.sv
rtl/conv1d_multichannel_relu_unit.sv
tb/conv1d_result_checker.sv
tb/testbench.sv
